/* sv/tsr_pkg.sv */
package tsr_pkg;

	localparam int DEF_CHANNELS     = 32;
	localparam int DEF_RING_SECONDS = 1024;
	localparam int MAX_BACKFILL_GAP = 10;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_PUSH   = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [1:0] STATUS_FAULT = 2'd3;

	// One classified command on its way from the front end to the back end.
	// For a push, seconds is the push second and first is where the fill starts.
	// For a read, first carries the requested second as well.
	typedef struct packed {
		logic [1:0]  cmd;
		logic        chan_ok;
		logic [4:0]  channel;
		logic [31:0] word;
		logic [1:0]  status;
		logic [31:0] seconds;
		logic [31:0] first;
	} tsr_entry_t;

endpackage

/* sv/tsr_front.sv */
module tsr_front import tsr_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [4:0]  channel,
	input  logic [31:0] sample_word,
	input  logic [1:0]  sample_status,
	input  logic [31:0] seconds,
	input  logic        q_full,
	input  logic        hold,
	output logic        q_push,
	output tsr_entry_t  q_entry
);

	logic        accept;
	logic        chan_ok;
	logic        backfill;
	logic [31:0] gap;
	logic [31:0] prev_push_q;

	assign cmd_stall = q_full | hold;
	assign accept    = cmd_valid & ~cmd_stall;
	assign chan_ok   = {4'b0, channel} < 9'(CHANNELS);

	// A previous push second of zero means there was no push yet.
	assign gap      = seconds - prev_push_q;
	assign backfill = (prev_push_q != 32'd0) && (prev_push_q < seconds) &&
		(gap <= 32'(MAX_BACKFILL_GAP));

	always_comb begin
		q_entry.cmd     = command;
		q_entry.chan_ok = chan_ok;
		q_entry.channel = channel;
		q_entry.word    = sample_word;
		q_entry.status  = sample_status;
		q_entry.seconds = seconds;
		q_entry.first   = seconds;
		if (command == CMD_PUSH && backfill) begin
			q_entry.first = prev_push_q + 32'd1;
		end
	end

	// Updates to channels that do not exist and the unused code are dropped here.
	always_comb begin
		case (command) inside
			CMD_UPDATE: q_push = accept & chan_ok;
			CMD_PUSH, CMD_READ: q_push = accept;
			default: q_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_push_q <= 32'd0;
		end else if (accept && command == CMD_PUSH) begin
			prev_push_q <= seconds;
		end
	end

endmodule

/* sv/tsr_queue.sv */
module tsr_queue import tsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tsr_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output tsr_entry_t head
);

	localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	tsr_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/tsr_mod.sv */
module tsr_mod import tsr_pkg::*; #(
	parameter int RING_SECONDS = DEF_RING_SECONDS,
	localparam int SLOT_W = $clog2(RING_SECONDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       dividend,
	output logic              done,
	output logic [SLOT_W-1:0] rem
);

	localparam bit IS_POW2 = (RING_SECONDS & (RING_SECONDS - 1)) == 0;

	if (IS_POW2) begin : g_mask
		logic              done_q;
		logic [SLOT_W-1:0] rem_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				rem_q <= dividend[SLOT_W-1:0];
			end
		end

		assign done = done_q;
		assign rem  = rem_q;
	end else begin : g_recip
		// The quotient comes from a scaled reciprocal. The estimate is at most one
		// below the true quotient, so a single compare and subtract finishes it.
		localparam logic [63:0] RECIP = (64'd1 << (32 + SLOT_W)) / 64'(RING_SECONDS);

		logic [3:0]        stage_q;
		logic              done_q;
		logic [31:0]       dividend_q;
		logic [47:0]       prod_lo_s1;
		logic [48:0]       prod_hi_s1;
		logic [64:0]       scaled;
		logic [31:0]       quot_s2;
		logic [31:0]       back_s3;
		logic [31:0]       diff;
		logic [SLOT_W-1:0] rem_q;

		assign scaled = {17'd0, prod_lo_s1} + {prod_hi_s1, 16'd0};
		assign diff   = dividend_q - back_s3;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_q <= '0;
				done_q  <= 1'b0;
			end else begin
				stage_q <= {stage_q[2:0], start};
				done_q  <= stage_q[3];
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				dividend_q <= dividend;
			end
			if (stage_q[0]) begin
				prod_lo_s1 <= 48'(dividend_q) * 48'(RECIP[15:0]);
				prod_hi_s1 <= 49'(dividend_q) * 49'(RECIP[32:16]);
			end
			if (stage_q[1]) begin
				quot_s2 <= 32'(scaled >> (32 + SLOT_W));
			end
			if (stage_q[2]) begin
				back_s3 <= 32'(quot_s2 * 32'(RING_SECONDS));
			end
			if (stage_q[3]) begin
				rem_q <= (diff >= 32'(RING_SECONDS)) ?
					SLOT_W'(diff - 32'(RING_SECONDS)) : diff[SLOT_W-1:0];
			end
		end

		assign done = done_q;
		assign rem  = rem_q;
	end

endmodule

/* sv/tsr_back.sv */
module tsr_back import tsr_pkg::*; #(
	parameter int CHANNELS     = DEF_CHANNELS,
	parameter int RING_SECONDS = DEF_RING_SECONDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  tsr_entry_t  q_head,
	output logic        q_pop,
	output logic        clearing,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        read_hit,
	output logic [31:0] read_word
);

	localparam int SLOT_W     = $clog2(RING_SECONDS);
	localparam int CH_W       = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int ROW_W      = 32 + CHANNELS;
	localparam int WORD_DEPTH = RING_SECONDS << CH_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SECONDS - 1);
	localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(CHANNELS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   slot_d;
	logic [SLOT_W-1:0]   clr_q;
	logic [CH_W-1:0]     ch_q;
	logic [CH_W-1:0]     ch_d;
	logic [CH_W+4:0]     ent_ext;
	logic [CH_W+4:0]     head_ext;
	logic [CH_W-1:0]     rch;
	logic [CH_W-1:0]     head_ch;
	tsr_entry_t          ent_q;
	logic [31:0]         t_q;
	logic [CHANNELS-1:0] valid_acc_q;
	logic [CHANNELS-1:0] valid_row;
	logic [CHANNELS-1:0] row_valid;
	logic [CHANNELS-1:0] cur_set_q;

	logic [33:0]         cur_mem [CHANNELS];
	logic [33:0]         cur_rd;
	logic [ROW_W-1:0]    row_mem [RING_SECONDS];
	logic [ROW_W-1:0]    row_rd;
	logic [ROW_W-1:0]    row_wdata;
	logic [SLOT_W-1:0]   row_waddr;
	logic                row_we;
	logic [31:0]         word_mem [WORD_DEPTH];
	logic [31:0]         word_rd;

	logic                mod_start;
	logic                mod_done;
	logic [SLOT_W-1:0]   mod_rem;
	logic                cur_ok;
	logic                skip;
	logic                last_ch;
	logic                sec_done;
	logic                hit;
	logic                out_full_q;
	logic                out_hit_q;
	logic [31:0]         out_word_q;

	tsr_mod #(
		.RING_SECONDS(RING_SECONDS)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(q_head.first),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	assign ent_ext  = {{CH_W{1'b0}}, ent_q.channel};
	assign head_ext = {{CH_W{1'b0}}, q_head.channel};
	assign rch      = ent_ext[CH_W-1:0];
	assign head_ch  = head_ext[CH_W-1:0];

	assign clearing  = state_q == ST_CLEAR;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty &&
		(q_head.cmd != CMD_READ || !out_full_q);
	assign mod_start = q_pop && q_head.cmd != CMD_UPDATE;

	assign cur_ok    = cur_rd[33:32] != STATUS_FAULT;
	assign row_valid = row_rd[CHANNELS-1:0];
	assign skip      = row_rd[ROW_W-1 -: 32] == t_q;
	assign last_ch   = ch_q == LAST_CH;
	assign sec_done  = (state_q == ST_CHECK && skip) || (state_q == ST_COPY && last_ch);
	assign hit       = ent_q.chan_ok && (row_rd[ROW_W-1 -: 32] == ent_q.seconds) &&
		row_valid[rch];

	always_comb begin
		valid_row       = valid_acc_q;
		valid_row[ch_q] = cur_ok;
	end

	always_comb begin
		state_d = state_q;
		slot_d  = slot_q;
		ch_d    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (mod_start) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					slot_d  = mod_rem;
					state_d = (ent_q.cmd == CMD_READ) ? ST_READ : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!skip) begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (!last_ch) begin
					ch_d = ch_q + 1'b1;
				end
			end
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// End of one second of a push: either the push is complete or the next
		// second follows in the neighboring slot.
		if (sec_done) begin
			if (t_q == ent_q.seconds) begin
				state_d = ST_IDLE;
			end else begin
				state_d = ST_CHECK;
				slot_d  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			slot_q     <= '0;
			ch_q       <= '0;
			out_full_q <= 1'b0;
			cur_set_q  <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			ch_q    <= ch_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_READ) begin
				out_full_q <= 1'b1;
			end else if (out_full_q && !rsp_stall) begin
				out_full_q <= 1'b0;
			end
			if (q_pop && q_head.cmd == CMD_UPDATE) begin
				cur_set_q[head_ch] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_head;
			t_q   <= q_head.first;
		end else if (sec_done && t_q != ent_q.seconds) begin
			t_q <= t_q + 32'd1;
		end
		if (state_q == ST_COPY) begin
			valid_acc_q <= valid_row;
		end
		if (state_q == ST_READ) begin
			out_hit_q  <= hit;
			out_word_q <= hit ? word_rd : 32'd0;
		end
	end

	// Channel values: written by updates, read in channel order during a fill.
	// A channel that has never been updated reads as a zero word with status ok.
	always_ff @(posedge clk) begin
		if (q_pop && q_head.cmd == CMD_UPDATE) begin
			cur_mem[head_ch] <= {q_head.status, q_head.word};
		end
		cur_rd <= cur_set_q[ch_d] ? cur_mem[ch_d] : 34'd0;
	end

	// Each slot row holds the stamp and one valid bit per channel. The row is
	// written once, on the last channel of a fill, or by the clearing sweep.
	assign row_we    = (state_q == ST_CLEAR) || (state_q == ST_COPY && last_ch);
	assign row_waddr = (state_q == ST_CLEAR) ? clr_q : slot_q;
	assign row_wdata = (state_q == ST_CLEAR) ? '0 : {t_q, valid_row};

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		row_rd <= row_mem[slot_d];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COPY && cur_ok) begin
			word_mem[{slot_q, ch_q}] <= cur_rd[31:0];
		end
		word_rd <= word_mem[{slot_d, rch}];
	end

	assign rsp_valid = out_full_q;
	assign read_hit  = out_hit_q;
	assign read_word = out_word_q;

endmodule

/* sv/timestamped_snapshot_ring.sv */
// The back end takes one command at a time. The slot index is the second modulo RING_SECONDS,
// taken from the low bits when RING_SECONDS is a power of two and else from a reciprocal
// multiply. A push fills up to 10 seconds, copying the CHANNELS channel values for each second
// whose slot is not already stamped with it. A 4-entry queue sits in front of the back end.
// Reset clears stamps and valid bits in a sweep over all RING_SECONDS slots during which no
// beat is taken.
module timestamped_snapshot_ring import tsr_pkg::*; #(
	parameter int CHANNELS     = DEF_CHANNELS,
	parameter int RING_SECONDS = DEF_RING_SECONDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [4:0]  channel,
	input  logic [31:0] sample_word,
	input  logic [1:0]  sample_status,
	input  logic [31:0] seconds,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        read_hit,
	output logic [31:0] read_word
);

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	logic       clearing;
	tsr_entry_t q_entry;
	tsr_entry_t q_head;

	tsr_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.channel      (channel),
		.sample_word  (sample_word),
		.sample_status(sample_status),
		.seconds      (seconds),
		.q_full       (q_full),
		.hold         (clearing),
		.q_push       (q_push),
		.q_entry      (q_entry)
	);

	tsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	tsr_back #(
		.CHANNELS    (CHANNELS),
		.RING_SECONDS(RING_SECONDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.read_hit (read_hit),
		.read_word(read_word)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command written into a full queue");

	a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(cmd_valid && !cmd_stall))
		else $error("command beat taken during the clearing sweep");

	a_miss_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !read_hit) |-> (read_word == 32'd0))
		else $error("read miss with a nonzero word");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

endmodule

/* sim/tb_top.sv */
module tb_top import tsr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH  = DEF_CHANNELS;
	localparam int RING = DEF_RING_SECONDS;

	localparam logic [1:0] CMD_UNUSED      = 2'd3;
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ALARM_HI = 2'd1;
	localparam logic [1:0] STATUS_ALARM_LO = 2'd2;

	// Two copies of the ring state: one follows the stimulus as it is planned,
	// the other follows the beats as the block takes them.
	localparam int PLAN  = 0;
	localparam int CHECK = 1;

	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 500;
	localparam int CALM_TAIL    = 100;
	localparam int SETTLE       = 400;
	localparam int LIMIT        = 1000000;

	typedef struct {
		bit [1:0]  command;
		bit [4:0]  channel;
		bit [31:0] word;
		bit [1:0]  status;
		bit [31:0] seconds;
	} ring_cmd_t;

	typedef struct {
		bit        hit;
		bit [31:0] word;
	} read_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  command = CMD_UPDATE;
	logic [4:0]  channel = '0;
	logic [31:0] sample_word = '0;
	logic [1:0]  sample_status = STATUS_OK;
	logic [31:0] seconds = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        read_hit;
	logic [31:0] read_word;

	bit [31:0] live_word [2][NCH];
	bit [1:0]  live_status [2][NCH];
	bit [31:0] slot_stamp [2][RING];
	bit [31:0] snap_word [2][NCH][RING];
	bit        snap_valid [2][NCH][RING];
	bit [31:0] prev_push_sec [2];

	ring_cmd_t    pending [$];
	read_answer_t answers [$];

	bit cmd_fire;
	int gap_left, stall_left, hold_left;
	bit hold_done;
	int beats_sent, calm_from = 32'h7fffffff;
	int planned_items, errors, cycles;
	int beats_taken, pushes_taken, reads_checked, hits_seen;

	timestamped_snapshot_ring uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.channel(channel),
		.sample_word(sample_word),
		.sample_status(sample_status),
		.seconds(seconds),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.read_hit(read_hit),
		.read_word(read_word)
	);

	always #5ns clk = ~clk;

	function automatic void fill_second(int v, bit [31:0] t);
		int unsigned s;
		s = t % RING;
		if (slot_stamp[v][s] == t)
			return;
		slot_stamp[v][s] = t;
		for (int c = 0; c < NCH; c++) begin
			if (live_status[v][c] != STATUS_FAULT) begin
				snap_word[v][c][s]  = live_word[v][c];
				snap_valid[v][c][s] = 1'b1;
			end else begin
				snap_valid[v][c][s] = 1'b0;
			end
		end
	endfunction

	// Returns 1 when the command yields a read answer.
	function automatic bit ring_step(int v, ring_cmd_t b, output read_answer_t ans);
		bit [31:0]   first;
		bit [32:0]   t;
		int unsigned s;
		ans = '{hit: 1'b0, word: 32'd0};
		ring_step = 1'b0;
		case (b.command)
			CMD_UPDATE: begin
				if (b.channel < NCH) begin
					live_word[v][b.channel]   = b.word;
					live_status[v][b.channel] = b.status;
				end
			end
			CMD_PUSH: begin
				first = b.seconds;
				if (prev_push_sec[v] != 0 && prev_push_sec[v] < b.seconds &&
						b.seconds - prev_push_sec[v] <= MAX_BACKFILL_GAP)
					first = prev_push_sec[v] + 1;
				prev_push_sec[v] = b.seconds;
				// Widened counter so a fill ending at the top second does not wrap.
				for (t = first; t <= {1'b0, b.seconds}; t++)
					fill_second(v, t[31:0]);
			end
			CMD_READ: begin
				s = b.seconds % RING;
				if (b.channel < NCH && slot_stamp[v][s] == b.seconds &&
						snap_valid[v][b.channel][s])
					ans = '{hit: 1'b1, word: snap_word[v][b.channel][s]};
				ring_step = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic ring_cmd_t mk(bit [1:0] cmd, bit [4:0] ch, bit [31:0] w,
			bit [1:0] st, bit [31:0] sec);
		ring_cmd_t b;
		b = '{command: cmd, channel: ch, word: w, status: st, seconds: sec};
		return b;
	endfunction

	function automatic void add_item(ring_cmd_t b);
		read_answer_t dummy;
		void'(ring_step(PLAN, b, dummy));
		pending.push_back(b);
		if (b.command != CMD_UNUSED)
			planned_items++;
	endfunction

	function automatic bit [1:0] pick_status();
		if ($urandom_range(0, 4) == 0)
			return STATUS_FAULT;
		return 2'($urandom_range(0, 2));
	endfunction

	function automatic bit [31:0] pick_push_second();
		int r;
		bit [31:0] last;
		r = $urandom_range(0, 99);
		last = prev_push_sec[PLAN];
		if (r < 60)
			return last + 1;
		if (r < 75)
			return last + $urandom_range(2, 10);
		if (r < 83)
			return last + $urandom_range(11, 40);
		if (r < 90)
			return last - $urandom_range(0, 5);
		if (r < 95)
			return $urandom;
		return 32'hffffffff - $urandom_range(0, 12);
	endfunction

	function automatic bit [31:0] pick_read_second();
		int r;
		bit [31:0] base;
		r = $urandom_range(0, 99);
		base = prev_push_sec[PLAN] - $urandom_range(0, 12);
		if (r < 60)
			return base;
		if (r < 75)
			return base + RING * $urandom_range(1, 3);
		if (r < 85)
			return prev_push_sec[PLAN] + $urandom_range(1, 3);
		return $urandom;
	endfunction

	function automatic void report(string what);
		errors++;
		if (errors <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending.size() != 0 || cmd_valid || answers.size() != 0);
	endtask

	// Command side: one beat per handshake, with short random gaps.
	always @(negedge clk) begin
		ring_cmd_t b;
		if (!cmd_valid || cmd_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (beats_sent < calm_from && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(0, 5);
				cmd_valid <= 1'b0;
			end else if (pending.size() > 0) begin
				b = pending.pop_front();
				command       <= b.command;
				channel       <= b.channel;
				sample_word   <= b.word;
				sample_status <= b.status;
				seconds       <= b.seconds;
				cmd_valid     <= 1'b1;
				beats_sent++;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Response side: random stall bursts plus one long hold-off so the
	// command buffer fills and the block pushes back on its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (!hold_done && beats_sent >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (beats_sent < calm_from && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 5);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		ring_cmd_t    b;
		read_answer_t ans, want;
		cmd_fire = cmd_valid && cmd_stall === 1'b0;
		if (cmd_fire) begin
			b = mk(command, channel, sample_word, sample_status, seconds);
			beats_taken++;
			if (b.command == CMD_PUSH)
				pushes_taken++;
			if (ring_step(CHECK, b, ans))
				answers.push_back(ans);
		end
		if (rsp_valid === 1'b1 && !rsp_stall) begin
			if (answers.size() == 0) begin
				report($sformatf("result with nothing expected: hit=%0b word=%08h",
					read_hit, read_word));
			end else begin
				want = answers.pop_front();
				reads_checked++;
				if (want.hit)
					hits_seen++;
				if (read_hit !== want.hit || read_word !== want.word)
					report($sformatf("expected hit=%0b word=%08h, got hit=%0b word=%08h",
						want.hit, want.word, read_hit, read_word));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				answers.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		bit [4:0]  ch;
		bit [31:0] sec;
		int        n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Second zero right after reset: the stamp matches but nothing is valid.
		add_item(mk(CMD_READ, 5'd0, 32'd0, STATUS_OK, 32'd0));
		add_item(mk(CMD_UPDATE, 5'd0, 32'h00000000, STATUS_OK, 32'd0));
		add_item(mk(CMD_UPDATE, 5'd31, 32'hffffffff, STATUS_ALARM_HI, 32'd0));
		add_item(mk(CMD_UPDATE, 5'd5, 32'ha5a5a5a5, STATUS_ALARM_LO, 32'd0));
		add_item(mk(CMD_UPDATE, 5'd6, 32'h12345678, STATUS_OK, 32'd0));
		add_item(mk(CMD_UNUSED, 5'd31, 32'hffffffff, STATUS_FAULT, 32'hffffffff));
		// Push at second zero: no earlier push and the stamp already matches.
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd0));
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd1));
		add_item(mk(CMD_UPDATE, 5'd6, 32'hdeadbeef, STATUS_FAULT, 32'd0));
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd5));
		// Gap of exactly ten seconds is back-filled.
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd15));
		add_item(mk(CMD_READ, 5'd31, 32'd0, STATUS_OK, 32'd15));
		add_item(mk(CMD_READ, 5'd5, 32'd0, STATUS_OK, 32'd10));
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd1025));
		add_item(mk(CMD_READ, 5'd6, 32'd0, STATUS_OK, 32'd1025));
		add_item(mk(CMD_READ, 5'd0, 32'd0, STATUS_OK, 32'd1));
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd1025));
		// Gap of eleven: only the current second is filled.
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd1036));
		add_item(mk(CMD_READ, 5'd0, 32'd0, STATUS_OK, 32'd1030));
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'd1030));
		add_item(mk(CMD_READ, 5'd0, 32'd0, STATUS_OK, 32'd1030));
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'hfffffff6));
		add_item(mk(CMD_PUSH, 5'd0, 32'd0, STATUS_OK, 32'hffffffff));
		add_item(mk(CMD_READ, 5'd31, 32'd0, STATUS_OK, 32'hffffffff));
		add_item(mk(CMD_READ, 5'd0, 32'd0, STATUS_OK, 32'hfffffffa));
		add_item(mk(CMD_READ, 5'd4, 32'd0, STATUS_OK, 32'd1025));

		// The sender pauses here until every read answer has come back.
		wait_idle();

		n = planned_items;
		while (planned_items - n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85) begin
				repeat ($urandom_range(0, 4)) begin
					ch = 5'($urandom_range(0, NCH - 1));
					add_item(mk(CMD_UPDATE, ch, $urandom, pick_status(), $urandom));
				end
				add_item(mk(CMD_PUSH, 5'($urandom), $urandom, 2'($urandom),
					pick_push_second()));
				repeat ($urandom_range(0, 4)) begin
					sec = pick_read_second();
					add_item(mk(CMD_READ, 5'($urandom), $urandom, 2'($urandom), sec));
				end
			end else begin
				add_item(mk(2'($urandom_range(0, 3)), 5'($urandom), $urandom,
					2'($urandom), $urandom));
			end
		end
		calm_from = beats_sent + pending.size() - CALM_TAIL;

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (answers.size() != 0)
			report($sformatf("%0d read answers never arrived", answers.size()));

		$display("Took %0d command beats (%0d pushes); checked %0d read answers, %0d hits.",
			beats_taken, pushes_taken, reads_checked, hits_seen);
		$display("Mismatches: %0d", errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/tsr_pkg.sv
sv/tsr_front.sv
sv/tsr_queue.sv
sv/tsr_mod.sv
sv/tsr_back.sv
sv/timestamped_snapshot_ring.sv
sim/tb_top.sv
